[rtl/ikhm_pkg.sv]
// Package for the integer key hash map: types, codes and the integer mix.
package ikhm_pkg;

	localparam int unsigned DEF_BUCKETS    = 256;
	localparam int unsigned DEF_WAYS       = 4;
	localparam int unsigned DEF_VALUE_BITS = 32;
	localparam int unsigned KEY_W          = 32;
	localparam int unsigned CFG_W          = 9;
	localparam int unsigned COUNT_W        = 11;

	typedef enum logic [1:0] {
		CMD_PUT    = 2'd0,
		CMD_GET    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_MIX,
		S_MOD,
		S_SCAN,
		S_WAIT,
		S_ACT,
		S_OUT
	} state_t;

	// one step of the six-step mix; arithmetic right shifts
	function automatic logic [31:0] mix_step(input logic [31:0] k, input logic [2:0] idx);
		logic [31:0] r;
		begin
			unique case (idx)
				3'd0: r = k + ~(k << 15);
				3'd1: r = k ^ 32'($signed(k) >>> 10);
				3'd2: r = k + (k << 3);
				3'd3: r = k ^ 32'($signed(k) >>> 6);
				3'd4: r = k + ~(k << 11);
				3'd5: r = k ^ 32'($signed(k) >>> 16);
				default: r = k;
			endcase
			return r;
		end
	endfunction

endpackage

[rtl/integer_key_hash_map.sv]
// Top level of the integer key hash map: sequencer, slot memories and stream ports.
//
// Usage: items enter on the s_axis channel (tdata = command, key, value), one
// result leaves on m_axis per item (tdata = status, found, value_out,
// entry_count). The cfg channel writes table_size (buckets in use); write it
// only while idle. Zero counts as 1, values above BUCKETS saturate.
// Per item: the mix (one shift-add step a cycle), then restoring modulo (one
// quotient bit a cycle), then a scan of the bucket through the single read
// port of the key and value memories, a wait state and an update state; then
// the result is presented and m_axis_tvalid rises. A new item is taken only
// after the result has been taken.
// s_axis_tready is high only in idle; one item at a time.
// The result sits in an output register until m_axis_tready; the block holds
// there until it is taken, and each stalled cycle lengthens the item time.
// Reset: a clearing pass writes every key slot invalid, one slot a cycle,
// with s_axis_tready and cfg_ready low; the live count clears and table_size
// returns to BUCKETS at once.
// Values are undefined until written but are only used from valid slots.
module integer_key_hash_map #(
	parameter int unsigned BUCKETS    = ikhm_pkg::DEF_BUCKETS,
	parameter int unsigned WAYS       = ikhm_pkg::DEF_WAYS,
	parameter int unsigned VALUE_BITS = ikhm_pkg::DEF_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // [1:0] command, [33:2] key, [65:34] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [1:0] status, [2] found, [34:3] value_out, [45:35] entry_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);

	localparam int unsigned SLOTS  = BUCKETS * WAYS;
	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned DIV_W  = ikhm_pkg::CFG_W + 1;  // remainder + shifted bit
	localparam int unsigned WCNT_W = $clog2(WAYS + 1) + 1;
	localparam int unsigned VO_W   = (VALUE_BITS < 32) ? VALUE_BITS : 32;

	ikhm_pkg::state_t state_q, state_d;

	logic [ikhm_pkg::CFG_W-1:0] tsize_q;
	logic [ikhm_pkg::CFG_W-1:0] ts_eff;
	logic [1:0]                 cmd_q;
	logic [31:0]                key_q;
	logic [VALUE_BITS-1:0]      val_q;
	logic [31:0]                mix_q;
	logic [2:0]                 step_q;
	logic [4:0]                 bit_q;
	logic [ikhm_pkg::CFG_W-1:0] rem_q;
	logic [WCNT_W-1:0]          way_q;
	logic [SLOT_W-1:0]          base_q;
	logic                       hit_q, free_q;
	logic [WAY_W-1:0]           hit_way_q, free_way_q;
	logic [ikhm_pkg::COUNT_W-1:0] count_q;
	logic [SLOT_W-1:0]          clr_q;

	// key slot: [32] valid, [31:0] key
	logic [ikhm_pkg::KEY_W:0]   key_mem [SLOTS];
	logic [VALUE_BITS-1:0]      val_mem [SLOTS];
	logic [ikhm_pkg::KEY_W:0]   rd_key_q;
	logic [VALUE_BITS-1:0]      rd_val_q;
	logic [WAY_W-1:0]           rd_way_q;
	logic                       rd_pend_q;

	logic [1:0]  o_status_q;
	logic        o_found_q;
	logic [31:0] o_value_q;

	logic [DIV_W-1:0] trial;
	logic [SLOT_W-1:0] rd_addr;
	logic              rd_en;
	logic              in_acc;
	logic              mem_we;
	logic              rm_we;
	logic              clr_en;
	logic              key_we;
	logic [SLOT_W-1:0] key_wa;
	logic [ikhm_pkg::KEY_W:0] key_wd;
	logic [SLOT_W-1:0] wr_addr;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = (state_q == ikhm_pkg::S_IDLE);

	always_comb begin
		if (tsize_q == '0)
			ts_eff = ikhm_pkg::CFG_W'(1);
		else if (32'(tsize_q) > BUCKETS)
			ts_eff = ikhm_pkg::CFG_W'(BUCKETS);
		else
			ts_eff = tsize_q;
	end

	// restoring divide: shift in one mix bit per cycle
	assign trial   = {rem_q, mix_q[bit_q]};
	assign rd_addr = base_q + SLOT_W'(way_q);
	assign rd_en   = (state_q == ikhm_pkg::S_SCAN) && (way_q < WCNT_W'(WAYS));

	// next state and outputs
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			ikhm_pkg::S_CLR:  if (clr_q == SLOT_W'(SLOTS - 1)) state_d = ikhm_pkg::S_IDLE;
			ikhm_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = ikhm_pkg::S_MIX;
			end
			ikhm_pkg::S_MIX:  if (step_q == 3'd5) state_d = ikhm_pkg::S_MOD;
			ikhm_pkg::S_MOD:  if (bit_q == 5'd0) state_d = ikhm_pkg::S_SCAN;
			ikhm_pkg::S_SCAN: if (way_q == WCNT_W'(WAYS)) state_d = ikhm_pkg::S_WAIT;
			ikhm_pkg::S_WAIT: state_d = ikhm_pkg::S_ACT;
			ikhm_pkg::S_ACT:  state_d = ikhm_pkg::S_OUT;
			ikhm_pkg::S_OUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready)
					state_d = ikhm_pkg::S_IDLE;
			end
			default: state_d = ikhm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ikhm_pkg::S_CLR;
		else
			state_q <= state_d;
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q   <= ikhm_pkg::CFG_W'(BUCKETS);
			count_q   <= '0;
			rd_pend_q <= 1'b0;
			clr_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				tsize_q <= cfg_data;
			if (clr_en)
				clr_q <= clr_q + 1'b1;
			rd_pend_q <= rd_en;
			if (state_q == ikhm_pkg::S_ACT && hit_q == 1'b0 && free_q
				&& cmd_q == ikhm_pkg::CMD_PUT)
				count_q <= count_q + 1'b1;
			else if (rm_we)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ikhm_pkg::S_IDLE: begin
				cmd_q  <= s_axis_tdata[1:0];
				key_q  <= s_axis_tdata[33:2];
				mix_q  <= s_axis_tdata[33:2];
				val_q  <= VALUE_BITS'(s_axis_tdata[65:34]);
				step_q <= '0;
			end
			ikhm_pkg::S_MIX: begin
				mix_q  <= ikhm_pkg::mix_step(mix_q, step_q);
				step_q <= step_q + 3'd1;
				bit_q  <= 5'd31;
				rem_q  <= '0;
			end
			ikhm_pkg::S_MOD: begin
				if (trial >= DIV_W'(ts_eff))
					rem_q <= ikhm_pkg::CFG_W'(trial - DIV_W'(ts_eff));
				else
					rem_q <= ikhm_pkg::CFG_W'(trial);
				bit_q  <= bit_q - 5'd1;
				way_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			ikhm_pkg::S_SCAN, ikhm_pkg::S_WAIT: begin
				if (rd_en)
					way_q <= way_q + 1'b1;
				if (rd_pend_q) begin
					if (rd_key_q[ikhm_pkg::KEY_W]) begin
						if (!hit_q && rd_key_q[31:0] == key_q) begin
							hit_q     <= 1'b1;
							hit_way_q <= rd_way_q;
							o_value_q <= 32'(rd_val_q[VO_W-1:0]);
						end
					end else if (!free_q) begin
						free_q     <= 1'b1;
						free_way_q <= rd_way_q;
					end
				end
			end
			ikhm_pkg::S_ACT: begin
				o_found_q  <= 1'b0;
				o_status_q <= ikhm_pkg::ST_OK;
				if (!(cmd_q == ikhm_pkg::CMD_GET && hit_q))
					o_value_q <= '0;
				unique case (cmd_q)
					ikhm_pkg::CMD_PUT: begin
						if (hit_q) o_found_q <= 1'b1;
						else if (!free_q) o_status_q <= ikhm_pkg::ST_FULL;
					end
					ikhm_pkg::CMD_GET, ikhm_pkg::CMD_REMOVE: begin
						if (hit_q) o_found_q <= 1'b1;
						else o_status_q <= ikhm_pkg::ST_NOTFOUND;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// bucket base from the final remainder, ready for the first scan read
	always_ff @(posedge clk) begin
		if (state_q == ikhm_pkg::S_MOD && bit_q == 5'd0) begin
			if (trial >= DIV_W'(ts_eff))
				base_q <= SLOT_W'(BKT_W'(trial - DIV_W'(ts_eff)) * WAYS);
			else
				base_q <= SLOT_W'(BKT_W'(trial) * WAYS);
		end
	end

	// slot memories: one read, one write port; remove and the clearing pass
	// write an invalid key slot
	assign mem_we  = (state_q == ikhm_pkg::S_ACT) && (cmd_q == ikhm_pkg::CMD_PUT)
		&& (hit_q || free_q);
	assign rm_we   = (state_q == ikhm_pkg::S_ACT) && hit_q
		&& (cmd_q == ikhm_pkg::CMD_REMOVE);
	assign clr_en  = (state_q == ikhm_pkg::S_CLR);
	assign wr_addr = base_q + SLOT_W'(hit_q ? hit_way_q : free_way_q);
	assign key_we  = clr_en || mem_we || rm_we;
	assign key_wa  = clr_en ? clr_q : wr_addr;
	assign key_wd  = mem_we ? {1'b1, key_q} : '0;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
			rd_way_q <= WAY_W'(way_q);
		end
		if (key_we)
			key_mem[key_wa] <= key_wd;
		if (mem_we)
			val_mem[wr_addr] <= val_q;
	end

	assign m_axis_tdata = {2'b00, count_q, o_value_q, o_found_q, o_status_q};

	// assertions
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input ready while a result is pending");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ikhm_pkg::COUNT_W'(SLOTS))
		else $error("live count beyond slot total");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && o_found_q |-> o_status_q == ikhm_pkg::ST_OK)
		else $error("found with error status");

endmodule
